// ===== hdl/tach_pkg.sv =====
// Shared constants and types for the pulse period tachometer.
package tach_pkg;

	localparam int TS_W       = 32;
	localparam int MIN_GAP_W  = 24;
	localparam int HOLES_W    = 8;
	localparam int GAIN_W     = 32;
	localparam int GAIN_FRAC  = 24;
	localparam int RPM_W      = 32;
	localparam int SPEED_W    = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// divisor is gap times holes; dividend is the fixed rpm numerator
	localparam int DVS_W     = TS_W + HOLES_W;
	localparam int NUM_W     = 34;
	localparam int DIV_CNT_W = $clog2(NUM_W);
	localparam int MUL_CNT_W = $clog2(RPM_W);

	localparam logic [NUM_W-1:0] RPM_NUM = 34'd15360000000;

	localparam logic [MIN_GAP_W-1:0] MIN_GAP_RST  = 24'd200;
	localparam logic [HOLES_W-1:0]   HOLES_RST    = 8'd20;
	localparam logic [GAIN_W-1:0]    GAIN_RST     = 32'd57094;
	localparam logic [TS_W-1:0]      INTERVAL_RST = 32'd100000;
	localparam logic [TS_W-1:0]      TIMEOUT_RST  = 32'd1000000;

	localparam logic OP_PULSE = 1'b0;
	localparam logic OP_CHECK = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_GAP  = 3'd0,
		CFG_HOLES    = 3'd1,
		CFG_GAIN     = 3'd2,
		CFG_INTERVAL = 3'd3,
		CFG_TIMEOUT  = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_DIV,
		ST_MUL,
		ST_EMIT
	} state_t;

endpackage

// ===== hdl/tach_if.sv =====
// Handshake channel interfaces: input events, results and register writes.
interface tach_in_if;
	logic                     valid;
	logic                     ready;
	logic                     op;
	logic [tach_pkg::TS_W-1:0] timestamp_us;

	modport source (output valid, output op, output timestamp_us, input ready);
	modport sink (input valid, input op, input timestamp_us, output ready);
endinterface

interface tach_out_if;
	logic                        valid;
	logic                        ready;
	logic [tach_pkg::RPM_W-1:0]   rpm_q8;
	logic [tach_pkg::SPEED_W-1:0] speed_q8;
	logic                        from_timeout;

	modport source (output valid, output rpm_q8, output speed_q8, output from_timeout,
		input ready);
	modport sink (input valid, input rpm_q8, input speed_q8, input from_timeout,
		output ready);
endinterface

interface tach_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [tach_pkg::CFG_IDX_W-1:0]  index;
	logic [tach_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/tach_div.sv =====
// Bit-serial divisor build (gap times holes) and restoring divider for rpm.
module tach_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [tach_pkg::TS_W-1:0]    gap,
	input  logic [tach_pkg::HOLES_W-1:0] holes,
	output logic                         done,
	output logic [tach_pkg::RPM_W-1:0]   rpm
);
	import tach_pkg::*;

	logic                 busy_q;
	logic                 mult_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [TS_W-1:0]      gap_q;
	logic [HOLES_W-1:0]   hsr_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DVS_W-1:0]     rem_q;
	logic [NUM_W-1:0]     num_q;

	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;
	logic [DVS_W-1:0] rem_nx;
	logic [DVS_W-1:0] dvs_nx;

	// one multiplier bit per cycle, MSB first
	assign dvs_nx = {dvs_q[DVS_W-2:0], 1'b0} + (hsr_q[HOLES_W-1] ? DVS_W'(gap_q) : '0);

	// one quotient bit per cycle; a zero divisor yields all ones and saturates below
	assign trial  = {rem_q, num_q[NUM_W-1]};
	assign diff   = trial - {1'b0, dvs_q};
	assign ge     = (trial >= {1'b0, dvs_q});
	assign rem_nx = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mult_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			mult_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q && mult_q) begin
			if (cnt_q == DIV_CNT_W'(HOLES_W - 1)) begin
				mult_q <= 1'b0;
				cnt_q  <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end else if (busy_q) begin
			if (cnt_q == DIV_CNT_W'(NUM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			gap_q <= gap;
			hsr_q <= holes;
			dvs_q <= '0;
			rem_q <= '0;
			num_q <= RPM_NUM;
		end else if (busy_q && mult_q) begin
			dvs_q <= dvs_nx;
			hsr_q <= {hsr_q[HOLES_W-2:0], 1'b0};
		end else if (busy_q) begin
			rem_q <= rem_nx;
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign rpm  = (|num_q[NUM_W-1:RPM_W]) ? '1 : num_q[RPM_W-1:0];

endmodule

// ===== hdl/tach_mul.sv =====
// Bit-serial shift-add multiplier: speed = (rpm * gain) >> 24, saturated.
module tach_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [tach_pkg::RPM_W-1:0]   a,
	input  logic [tach_pkg::GAIN_W-1:0]  b,
	output logic                         done,
	output logic [tach_pkg::SPEED_W-1:0] speed
);
	import tach_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic [GAIN_W-1:0]    b_q;
	logic [GAIN_W-1:0]    hi_q;
	logic [RPM_W-1:0]     lo_q;
	logic [GAIN_W:0]      sum;

	// lo_q holds the unconsumed multiplier bits and collects the low product bits
	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, b_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == MUL_CNT_W'(RPM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			b_q  <= b;
			hi_q <= '0;
			lo_q <= a;
		end else if (busy_q) begin
			hi_q <= sum[GAIN_W:1];
			lo_q <= {sum[0], lo_q[RPM_W-1:1]};
		end
	end

	assign done  = done_q;
	assign speed = (|hi_q[GAIN_W-1:GAIN_FRAC]) ? '1
		: {hi_q[GAIN_FRAC-1:0], lo_q[RPM_W-1:GAIN_FRAC]};

endmodule

// ===== hdl/pulse_period_tachometer.sv =====
// Wheel tachometer: measures rpm and speed from the period between encoder pulses.
// Each transaction on the pulse channel is a rising-edge pulse (op 0) or a timeout check
// (op 1) with a 32-bit microsecond timestamp; time differences wrap modulo 2^32. A pulse
// that passes the glitch filter runs a bit-serial multiply (gap times holes), a restoring
// divide for rpm and a bit-serial multiply for speed, and no new transaction is accepted
// until these finish; a first pulse, a glitch or a check item skips them. A result is
// held in an output register, so the next transaction is accepted while it waits to be
// taken. Registers are written over the cfg channel, which is always ready, and should
// only be written while the block is idle.
module pulse_period_tachometer (
	input  logic        clk,
	input  logic        arst_n,
	tach_in_if.sink     pulse,
	tach_out_if.source  result,
	tach_cfg_if.sink    cfg
);
	import tach_pkg::*;

	state_t state_q, state_d;

	logic [MIN_GAP_W-1:0] min_gap_q;
	logic [HOLES_W-1:0]   holes_q;
	logic [GAIN_W-1:0]    gain_q;
	logic [TS_W-1:0]      interval_q;
	logic [TS_W-1:0]      timeout_q;

	logic             op_q;
	logic [TS_W-1:0]  ts_q;
	logic [TS_W-1:0]  last_pulse_q;
	logic             have_pulse_q;
	logic [TS_W-1:0]  last_report_q;
	logic             have_report_q;
	logic             report_q;
	logic [RPM_W-1:0]   rpm_q;
	logic [SPEED_W-1:0] speed_q;

	logic               out_valid_q;
	logic [RPM_W-1:0]   out_rpm_q;
	logic [SPEED_W-1:0] out_speed_q;
	logic               out_timeout_q;

	logic [TS_W-1:0]    gap;
	logic [TS_W-1:0]    rep_gap;
	logic               gap_ok;
	logic               rep_due;
	logic               tmo_hit;
	logic               out_free;
	logic               accept;
	logic               div_start;
	logic               div_done;
	logic [RPM_W-1:0]   div_rpm;
	logic               mul_start;
	logic               mul_done;
	logic [SPEED_W-1:0] mul_speed;
	logic               emit_load;

	assign accept   = pulse.valid && pulse.ready;
	assign gap      = ts_q - last_pulse_q;
	assign rep_gap  = ts_q - last_report_q;
	assign gap_ok   = have_pulse_q && (gap >= TS_W'(min_gap_q));
	assign rep_due  = !have_report_q || (rep_gap >= interval_q);
	assign tmo_hit  = have_pulse_q && (gap >= timeout_q) && ((rpm_q != '0) || (speed_q != '0));
	assign out_free = !out_valid_q || result.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (pulse.valid) state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (op_q == OP_CHECK) state_d = tmo_hit ? ST_EMIT : ST_IDLE;
				else                  state_d = gap_ok ? ST_DIV : ST_IDLE;
			end
			ST_DIV:    if (div_done) state_d = ST_MUL;
			ST_MUL:    if (mul_done) state_d = report_q ? ST_EMIT : ST_IDLE;
			ST_EMIT:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		pulse.ready = 1'b0;
		div_start   = 1'b0;
		mul_start   = 1'b0;
		emit_load   = 1'b0;
		unique case (state_q)
			ST_IDLE:   pulse.ready = 1'b1;
			ST_DECIDE: div_start = (op_q == OP_PULSE) && gap_ok;
			ST_DIV:    mul_start = div_done;
			ST_MUL:    ;
			ST_EMIT:   emit_load = out_free;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_gap_q  <= MIN_GAP_RST;
			holes_q    <= HOLES_RST;
			gain_q     <= GAIN_RST;
			interval_q <= INTERVAL_RST;
			timeout_q  <= TIMEOUT_RST;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_MIN_GAP:  min_gap_q  <= cfg.data[MIN_GAP_W-1:0];
				CFG_HOLES:    holes_q    <= cfg.data[HOLES_W-1:0];
				CFG_GAIN:     gain_q     <= cfg.data[GAIN_W-1:0];
				CFG_INTERVAL: interval_q <= cfg.data[TS_W-1:0];
				CFG_TIMEOUT:  timeout_q  <= cfg.data[TS_W-1:0];
				default:      ;
			endcase
		end
	end

	// measurement state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pulse_q  <= '0;
			have_pulse_q  <= 1'b0;
			last_report_q <= '0;
			have_report_q <= 1'b0;
			report_q      <= 1'b0;
			rpm_q         <= '0;
			speed_q       <= '0;
		end else begin
			if (state_q == ST_DECIDE) begin
				if (op_q == OP_PULSE) begin
					last_pulse_q <= ts_q;
					have_pulse_q <= 1'b1;
					if (gap_ok) begin
						report_q <= rep_due;
						if (rep_due) begin
							last_report_q <= ts_q;
							have_report_q <= 1'b1;
						end
					end
				end else if (tmo_hit) begin
					rpm_q   <= '0;
					speed_q <= '0;
				end
			end
			if (div_done && state_q == ST_DIV) rpm_q <= div_rpm;
			if (mul_done && state_q == ST_MUL) speed_q <= mul_speed;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= pulse.op;
			ts_q <= pulse.timestamp_us;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)           out_valid_q <= 1'b0;
		else if (emit_load)    out_valid_q <= 1'b1;
		else if (result.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_rpm_q     <= rpm_q;
			out_speed_q   <= speed_q;
			out_timeout_q <= op_q;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.rpm_q8       = out_rpm_q;
	assign result.speed_q8     = out_speed_q;
	assign result.from_timeout = out_timeout_q;

	tach_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.gap    (gap),
		.holes  (holes_q),
		.done   (div_done),
		.rpm    (div_rpm)
	);

	tach_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (div_rpm),
		.b      (gain_q),
		.done   (mul_done),
		.speed  (mul_speed)
	);

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> state_q == ST_MUL)
		else $error("multiplier finished outside the multiply state");

	a_accept_decides: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_DECIDE)
		else $error("accepted transaction not evaluated next cycle");

	a_timeout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.from_timeout) |-> (result.rpm_q8 == '0 && result.speed_q8 == '0))
		else $error("timeout report carries nonzero values");

	a_emit_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_valid_q && !result.ready) |=> state_q == ST_EMIT)
		else $error("result dropped while output register was full");

endmodule

// ===== tb/pulse_period_tachometer_tb.sv =====
// Testbench for the pulse period tachometer: directed and random event traffic, predicted readings.
module pulse_period_tachometer_tb;
	import tach_pkg::*;

	localparam int SETTLE_CYCLES  = 120;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_EVENTS   = 200;

	typedef struct packed {
		logic [RPM_W-1:0]   rpm_q8;
		logic [SPEED_W-1:0] speed_q8;
		logic               from_timeout;
	} tach_reading_t;

	logic clk = 1'b0;
	logic arst_n;

	tach_in_if  pulse_ch ();
	tach_out_if result_ch ();
	tach_cfg_if cfg_ch ();

	pulse_period_tachometer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pulse  (pulse_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always #1 clk = ~clk;

	// register mirror
	logic [MIN_GAP_W-1:0] m_min_gap  = MIN_GAP_RST;
	logic [HOLES_W-1:0]   m_slots    = HOLES_RST;
	logic [GAIN_W-1:0]    m_gain     = GAIN_RST;
	logic [TS_W-1:0]      m_spacing  = INTERVAL_RST;
	logic [TS_W-1:0]      m_silence  = TIMEOUT_RST;

	// measurement state mirror
	logic [TS_W-1:0]    m_last_pulse  = '0;
	bit                 m_have_pulse  = 1'b0;
	logic [TS_W-1:0]    m_last_report = '0;
	bit                 m_have_report = 1'b0;
	logic [RPM_W-1:0]   m_rpm         = '0;
	logic [SPEED_W-1:0] m_speed       = '0;

	tach_reading_t   expected_readings[$];
	int              err_count   = 0;
	int              idle_cycles = 0;
	int unsigned     burst_left  = 0;
	logic [TS_W-1:0] now_us      = '0;

	cfg_idx_t reg_order[5] = '{CFG_MIN_GAP, CFG_HOLES, CFG_GAIN, CFG_INTERVAL, CFG_TIMEOUT};

	// Advances the mirror by one event; returns 1 when the event yields a reading.
	function automatic bit predict_reading(input logic op, input logic [TS_W-1:0] ts,
		output tach_reading_t rd);
		logic [TS_W-1:0] prev;
		logic [TS_W-1:0] gap;
		logic [63:0]     quot;
		logic [63:0]     prod;
		bit              had;
		rd = '0;
		if (op == OP_PULSE) begin
			prev = m_last_pulse;
			had = m_have_pulse;
			m_last_pulse = ts;
			m_have_pulse = 1'b1;
			if (!had)
				return 1'b0;
			gap = ts - prev;
			// glitch: pulse still becomes the last one, rpm and speed kept
			if (gap < TS_W'(m_min_gap))
				return 1'b0;
			if (gap == '0 || m_slots == '0) begin
				m_rpm = '1;
			end else begin
				quot = 64'(RPM_NUM) / (64'(gap) * 64'(m_slots));
				m_rpm = (quot > 64'hFFFF_FFFF) ? '1 : quot[RPM_W-1:0];
			end
			prod = (64'(m_rpm) * 64'(m_gain)) >> GAIN_FRAC;
			m_speed = (prod > 64'hFFFF_FFFF) ? '1 : prod[SPEED_W-1:0];
			if (!m_have_report || (ts - m_last_report) >= m_spacing) begin
				m_last_report = ts;
				m_have_report = 1'b1;
				rd.rpm_q8 = m_rpm;
				rd.speed_q8 = m_speed;
				rd.from_timeout = 1'b0;
				return 1'b1;
			end
			return 1'b0;
		end
		if (!m_have_pulse)
			return 1'b0;
		if ((ts - m_last_pulse) < m_silence)
			return 1'b0;
		if (m_rpm == '0 && m_speed == '0)
			return 1'b0;
		// zero report leaves the report timing untouched
		m_rpm = '0;
		m_speed = '0;
		rd.from_timeout = 1'b1;
		return 1'b1;
	endfunction

	// result receiver: switches between always ready, random ready and long stalls
	int unsigned ready_mode      = 0;
	int unsigned ready_mode_left = 0;
	int unsigned stall_left      = 0;
	always @(posedge clk) begin
		if (ready_mode_left == 0) begin
			ready_mode = $urandom_range(0, 2);
			ready_mode_left = $urandom_range(50, 400);
		end else begin
			ready_mode_left--;
		end
		case (ready_mode)
			0: begin
				result_ch.ready <= 1'b1;
			end
			1: begin
				result_ch.ready <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				if (stall_left != 0) begin
					stall_left--;
					result_ch.ready <= 1'b0;
				end else begin
					result_ch.ready <= 1'b1;
					if ($urandom_range(0, 3) == 0)
						stall_left = $urandom_range(1, 24);
				end
			end
		endcase
	end

	// transaction monitor: mirror update, reading check, watchdog
	always @(posedge clk) begin
		tach_reading_t got;
		tach_reading_t want;
		tach_reading_t fresh;
		bit            moved;
		moved = 1'b0;
		if (arst_n === 1'b1) begin
			if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
				moved = 1'b1;
				got.rpm_q8 = result_ch.rpm_q8;
				got.speed_q8 = result_ch.speed_q8;
				got.from_timeout = result_ch.from_timeout;
				if (expected_readings.size() == 0) begin
					$error("unexpected reading: rpm_q8 %0d speed_q8 %0d from_timeout %0d",
						got.rpm_q8, got.speed_q8, got.from_timeout);
					err_count++;
				end else begin
					want = expected_readings.pop_front();
					if (got.rpm_q8 !== want.rpm_q8) begin
						$error("rpm_q8: expected %0d, actual %0d", want.rpm_q8, got.rpm_q8);
						err_count++;
					end
					if (got.speed_q8 !== want.speed_q8) begin
						$error("speed_q8: expected %0d, actual %0d", want.speed_q8, got.speed_q8);
						err_count++;
					end
					if (got.from_timeout !== want.from_timeout) begin
						$error("from_timeout: expected %0d, actual %0d", want.from_timeout,
							got.from_timeout);
						err_count++;
					end
				end
			end
			if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) begin
				moved = 1'b1;
				case (cfg_ch.index)
					CFG_MIN_GAP:  m_min_gap = cfg_ch.data[MIN_GAP_W-1:0];
					CFG_HOLES:    m_slots = cfg_ch.data[HOLES_W-1:0];
					CFG_GAIN:     m_gain = cfg_ch.data[GAIN_W-1:0];
					CFG_INTERVAL: m_spacing = cfg_ch.data[TS_W-1:0];
					CFG_TIMEOUT:  m_silence = cfg_ch.data[TS_W-1:0];
					default: ;
				endcase
			end
			if (pulse_ch.valid === 1'b1 && pulse_ch.ready === 1'b1) begin
				moved = 1'b1;
				if (predict_reading(pulse_ch.op, pulse_ch.timestamp_us, fresh))
					expected_readings.push_back(fresh);
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$error("watchdog: no transaction for %0d cycles", idle_cycles);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// one event transaction; the sender goes quiet between bursts
	task automatic send_event(input logic op, input logic [TS_W-1:0] ts);
		if (burst_left == 0) begin
			pulse_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 20);
		end
		burst_left--;
		pulse_ch.valid <= 1'b1;
		pulse_ch.op <= op;
		pulse_ch.timestamp_us <= ts;
		do @(posedge clk); while (pulse_ch.ready !== 1'b1);
	endtask

	task automatic pulse_after(input logic [TS_W-1:0] delta);
		now_us = now_us + delta;
		send_event(OP_PULSE, now_us);
	endtask

	// check relative to the most recent pulse time
	task automatic check_after(input logic [TS_W-1:0] delta);
		send_event(OP_CHECK, now_us + delta);
	endtask

	// hold off until every reading is in, then let a trailing measurement finish
	task automatic wait_drained();
		pulse_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_readings.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [MIN_GAP_W-1:0] gap_min,
		input logic [HOLES_W-1:0] slots, input logic [GAIN_W-1:0] gain,
		input logic [TS_W-1:0] spacing_us, input logic [TS_W-1:0] silence_us);
		logic [CFG_DATA_W-1:0] vals[5];
		vals[0] = CFG_DATA_W'(gap_min);
		vals[1] = CFG_DATA_W'(slots);
		vals[2] = gain;
		vals[3] = spacing_us;
		vals[4] = silence_us;
		for (int i = 0; i < 5; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= reg_order[i];
			cfg_ch.data <= vals[i];
			do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// reset values: check before any pulse, first pulse, glitch, interval gating, timeout
	task automatic test_reset_defaults();
		now_us = 32'd0;
		check_after(32'd5);
		pulse_after(32'd5);
		pulse_after(32'd1000);
		pulse_after(32'd50);
		pulse_after(32'd1000);
		pulse_after(32'd100000);
		check_after(32'd999999);
		check_after(32'd1000000);
		check_after(32'd1000010);
	endtask

	// register extremes, zero gap, zero holes, wrap, saturation, floored rpm
	task automatic test_config_extremes();
		wait_drained();
		program_regs('0, '0, '1, '0, '0);
		pulse_after(32'd0);
		check_after(32'd0);
		wait_drained();
		program_regs('0, 8'd255, '1, '0, '1);
		now_us = 32'hFFFF_FFF0;
		send_event(OP_PULSE, now_us);
		pulse_after(32'h20);
		pulse_after(32'd1);
		pulse_after(32'hFFFF_FFFF);
		check_after(32'd5);
		wait_drained();
		program_regs('1, 8'd1, '0, '1, '0);
		pulse_after(32'h00FF_FFFE);
		pulse_after(32'h00FF_FFFF);
		check_after(32'd0);
		send_event(OP_CHECK, 32'h0000_0000);
		send_event(OP_CHECK, 32'hFFFF_FFFF);
	endtask

	// phases of pulse trains with jitter, glitches, silences and noise
	task automatic test_random_traffic();
		logic [MIN_GAP_W-1:0] gap_min;
		logic [HOLES_W-1:0]   slots;
		logic [GAIN_W-1:0]    gain;
		logic [TS_W-1:0]      spacing_us;
		logic [TS_W-1:0]      silence_us;
		logic [TS_W-1:0]      period;
		int unsigned          pick;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph % 4)
				0: begin
					gap_min = MIN_GAP_W'($urandom_range(0, 3000));
					slots = HOLES_W'($urandom_range(1, 255));
					gain = $urandom;
					period = TS_W'(gap_min) + $urandom_range(0, 4000);
					spacing_us = $urandom_range(0, 3 * period);
					silence_us = $urandom_range(period, 20 * period);
				end
				1: begin
					gap_min = MIN_GAP_W'($urandom);
					slots = HOLES_W'($urandom);
					gain = $urandom;
					period = TS_W'(gap_min) + $urandom_range(0, 4000);
					spacing_us = $urandom_range(0, 4 * period);
					silence_us = $urandom_range(0, 8 * period);
				end
				2: begin
					gap_min = '0;
					slots = (ph < 4) ? 8'd255 : 8'd1;
					gain = '1;
					period = $urandom_range(0, 4000);
					spacing_us = '0;
					silence_us = '0;
				end
				default: begin
					gap_min = '1;
					slots = (ph < 4) ? 8'd255 : 8'd1;
					gain = (ph < 4) ? '1 : $urandom;
					period = TS_W'(gap_min) + $urandom_range(0, 4000);
					spacing_us = (ph < 4) ? '1 : '0;
					silence_us = (ph < 4) ? '1 : $urandom_range(period, 4 * period);
				end
			endcase
			wait_drained();
			program_regs(gap_min, slots, gain, spacing_us, silence_us);
			for (int n = 0; n < PHASE_EVENTS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 65)
					pulse_after(period + $urandom_range(0, period / 8));
				else if (pick < 75)
					pulse_after((gap_min == '0) ? '0 : $urandom_range(0, TS_W'(gap_min) - 1));
				else if (pick < 78)
					pulse_after('0);
				else if (pick < 82)
					pulse_after($urandom);
				else if (pick < 92)
					check_after($urandom_range(0, period));
				else if (pick < 99)
					check_after(silence_us + $urandom_range(0, period));
				else
					send_event(OP_CHECK, $urandom);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		pulse_ch.valid <= 1'b0;
		pulse_ch.op <= OP_PULSE;
		pulse_ch.timestamp_us <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_MIN_GAP;
		cfg_ch.data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_config_extremes();
		test_random_traffic();
		wait_drained();
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
